### hw/rtl/ir_ring_ball_direction_top_assert.svh
// Assertion macros for the IR ring direction block.
// Included by modules that check their own sequencing.
`ifndef IR_RING_BALL_DIRECTION_TOP_ASSERT_SVH
`define IR_RING_BALL_DIRECTION_TOP_ASSERT_SVH
// condition implies consequence on the same edge
`define IRB_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
// condition implies consequence on the next edge
`define IRB_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

### hw/rtl/irbd_pkg.sv
// Shared types, constants and tables for the IR ring direction block.
// No dependencies.
package irbd_pkg;
	localparam int SensorCount = 12;
	localparam int CountWidth  = 10;
	localparam int IdxW        = 4;
	localparam int CordicSteps = 16;
	localparam int AccW        = 40;
	localparam int Cw          = 18;  // signed Q16 sin/cos

	typedef enum logic [2:0] {
		REG_SPW = 3'd0, REG_MIN = 3'd1, REG_MAX = 3'd2, REG_ANG = 3'd3, REG_STR = 3'd4
	} reg_lo_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FILTER, ST_FILL, ST_SORT, ST_STR, ST_DIV, ST_VEC,
		ST_PRE, ST_CORD, ST_ROUND, ST_DONE
	} state_t;

	typedef logic [CountWidth-1:0] count_t;

	function automatic logic [31:0] atan_q16(input logic [3:0] i);
		logic [31:0] t;
		case (i)
			4'd0: t = 32'd2949120;  4'd1: t = 32'd1740967;
			4'd2: t = 32'd919879;   4'd3: t = 32'd466945;
			4'd4: t = 32'd234379;   4'd5: t = 32'd117304;
			4'd6: t = 32'd58666;    4'd7: t = 32'd29335;
			4'd8: t = 32'd14668;    4'd9: t = 32'd7334;
			4'd10: t = 32'd3667;    4'd11: t = 32'd1833;
			4'd12: t = 32'd917;     4'd13: t = 32'd458;
			4'd14: t = 32'd229;     default: t = 32'd115;
		endcase
		return t;
	endfunction

	// cos/sin of sensor k at k*30 degrees, Q16 values from the folded CORDIC
	function automatic logic signed [Cw-1:0] sens_cos(input logic [IdxW-1:0] k);
		logic signed [Cw-1:0] v;
		case (k)
			4'd0: v = 18'sd65536;   4'd1: v = 18'sd56759;
			4'd2: v = 18'sd32769;   4'd3: v = 18'sd0;
			4'd4: v = -18'sd32769;  4'd5: v = -18'sd56759;
			4'd6: v = -18'sd65536;  4'd7: v = -18'sd56759;
			4'd8: v = -18'sd32769;  4'd9: v = 18'sd0;
			4'd10: v = 18'sd32769;  default: v = 18'sd56759;
		endcase
		return v;
	endfunction

	function automatic logic signed [Cw-1:0] sens_sin(input logic [IdxW-1:0] k);
		logic signed [Cw-1:0] v;
		case (k)
			4'd0: v = 18'sd0;       4'd1: v = 18'sd32769;
			4'd2: v = 18'sd56759;   4'd3: v = 18'sd65536;
			4'd4: v = 18'sd56759;   4'd5: v = 18'sd32769;
			4'd6: v = 18'sd0;       4'd7: v = -18'sd32769;
			4'd8: v = -18'sd56759;  4'd9: v = -18'sd65536;
			4'd10: v = -18'sd56759; default: v = -18'sd32769;
		endcase
		return v;
	endfunction
endpackage

### hw/rtl/ir_ring_ball_direction_top.sv
// Top level of the IR ring ball direction block: counters, sequencer, APB registers.
// Depends on irbd_pkg, irbd_cordic and ir_ring_ball_direction_top_assert.svh.
//
// channel   | signals                               | handshake
// sample    | start, sensor_levels, busy            | taken when start & !busy
// result    | valid, ball_strength, ball_angle      | one-cycle strobe
// config    | psel penable pwrite paddr pwdata ...  | APB, pready tied high
//
// A sample that does not end a window leaves the block idle. A window end runs
// filter, fill (12), sort (66 compare steps), strength mean (up to 12 sum +
// 10 divide steps), vector sum (up to 12), CORDIC (16), rounding and done,
// using a single CORDIC instance.
// The result strobe follows in the first idle cycle.
// Reset clears counts and counters, presets config; the result cannot be stalled.
`include "ir_ring_ball_direction_top_assert.svh"
module ir_ring_ball_direction_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] sensor_levels,
	output logic        valid,
	output logic [9:0]  ball_strength,
	output logic signed [9:0] ball_angle,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int N  = irbd_pkg::SensorCount;
	localparam int IW = irbd_pkg::IdxW;
	localparam int CW = irbd_pkg::CountWidth;
	localparam int AW = irbd_pkg::AccW;

	irbd_pkg::state_t state_q, state_d;
	logic [CW-1:0] spw_q, min_q, max_q;
	logic [3:0]    ang_n_q, str_n_q;
	logic [CW-1:0] hit_q [N];
	logic [CW-1:0] w_q [N];
	logic [IW-1:0] idx_q [N];
	logic [CW-1:0] samp_q;
	logic [IW-1:0] i_q, j_q;
	logic [CW+IW-1:0] sum_q, quo_q;
	logic signed [AW-1:0] si_q, sj_q;
	logic signed [31:0] z;
	logic [9:0]    str_q;
	logic signed [9:0] ang_q;
	logic          valid_q;

	logic wr, accept, win_end;
	logic [CW-1:0] samp_nx;
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign busy   = (state_q != irbd_pkg::ST_IDLE);
	assign accept = start & ~busy;
	assign samp_nx = samp_q + 1'b1;
	assign win_end = (samp_nx >= spw_q);

	// register read mux
	always_comb begin
		prdata = '0;
		case (paddr[4:2])
			irbd_pkg::REG_SPW: prdata = 32'(spw_q);
			irbd_pkg::REG_MIN: prdata = 32'(min_q);
			irbd_pkg::REG_MAX: prdata = 32'(max_q);
			irbd_pkg::REG_ANG: prdata = 32'(ang_n_q);
			irbd_pkg::REG_STR: prdata = 32'(str_n_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spw_q <= 10'd255; min_q <= '0; max_q <= 10'd1023;
			ang_n_q <= 4'd4; str_n_q <= 4'd3;
		end else if (wr) begin
			case (paddr[4:2])
				irbd_pkg::REG_SPW: spw_q <= pwdata[CW-1:0];
				irbd_pkg::REG_MIN: min_q <= pwdata[CW-1:0];
				irbd_pkg::REG_MAX: max_q <= pwdata[CW-1:0];
				irbd_pkg::REG_ANG: ang_n_q <= pwdata[3:0];
				irbd_pkg::REG_STR: str_n_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// shared helpers for the sequencer
	logic [IW-1:0] ip, inx;
	logic [CW:0]   nsum;
	logic          swap;
	logic [3:0]    n_str, n_ang;
	logic [CW+IW-1:0] dsub;
	logic signed [AW-1:0] prod_s, prod_c;
	logic signed [AW-1:0] zr;
	logic signed [15:0] rdeg;
	logic signed [15:0] tsum;
	logic signed [15:0] tmod;

	assign ip  = (i_q == '0) ? IW'(N-1) : i_q - 1'b1;
	assign inx = (i_q == IW'(N-1)) ? '0 : i_q + 1'b1;
	assign nsum = {1'b0, w_q[ip]} + {1'b0, w_q[inx]};
	// higher count first, lower sensor index first on equal counts
	assign swap = (w_q[j_q] > w_q[i_q]) ||
		(w_q[j_q] == w_q[i_q] && idx_q[j_q] < idx_q[i_q]);
	assign n_str = (str_n_q == 0) ? 4'd1 : (str_n_q > 4'(N)) ? 4'(N) : str_n_q;
	assign n_ang = (ang_n_q > 4'(N)) ? 4'(N) : ang_n_q;
	assign dsub = (CW+IW)'(n_str) << j_q;
	assign prod_s = AW'($signed({1'b0, w_q[i_q]})) * AW'(irbd_pkg::sens_sin(idx_q[i_q]));
	assign prod_c = AW'($signed({1'b0, w_q[i_q]})) * AW'(irbd_pkg::sens_cos(idx_q[i_q]));
	assign zr   = (z >= 0) ? AW'((z + 32'sd32768) >>> 16) : -AW'((-z + 32'sd32768) >>> 16);
	assign rdeg = 16'(zr);
	// 270 + r stays within 0..719, one conditional subtract wraps it
	assign tsum = 16'sd270 + rdeg;
	assign tmod = (tsum >= 16'sd360) ? tsum - 16'sd360 : tsum;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			irbd_pkg::ST_IDLE:   if (accept && win_end) state_d = irbd_pkg::ST_FILTER;
			irbd_pkg::ST_FILTER: state_d = irbd_pkg::ST_FILL;
			irbd_pkg::ST_FILL:   if (i_q == IW'(N-1)) state_d = irbd_pkg::ST_SORT;
			irbd_pkg::ST_SORT:
				if (i_q == IW'(N-2) && j_q == IW'(N-1)) state_d = irbd_pkg::ST_STR;
			irbd_pkg::ST_STR:    if (i_q == n_str - 1'b1) state_d = irbd_pkg::ST_DIV;
			irbd_pkg::ST_DIV:    if (j_q == '0) state_d = irbd_pkg::ST_VEC;
			irbd_pkg::ST_VEC:    if (i_q >= IW'(n_ang)) state_d = irbd_pkg::ST_PRE;
			irbd_pkg::ST_PRE:    state_d = (si_q == 0) ? irbd_pkg::ST_DONE : irbd_pkg::ST_CORD;
			irbd_pkg::ST_CORD:   if (i_q == 4'd15) state_d = irbd_pkg::ST_ROUND;
			irbd_pkg::ST_ROUND:  state_d = irbd_pkg::ST_DONE;
			irbd_pkg::ST_DONE:   state_d = irbd_pkg::ST_IDLE;
			default:             state_d = irbd_pkg::ST_IDLE;
		endcase
	end

	irbd_cordic u_cordic (
		.clk  (clk),
		.load (state_q == irbd_pkg::ST_PRE),
		.step (state_q == irbd_pkg::ST_CORD),
		.iter (i_q),
		.y_in (sj_q),
		.x_in (si_q),
		.z    (z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irbd_pkg::ST_IDLE;
			samp_q <= '0;
			valid_q <= 1'b0;
			i_q <= '0; j_q <= '0;
			for (int k = 0; k < N; k++) hit_q[k] <= '0;
		end else begin
			state_q <= state_d;
			valid_q <= 1'b0;
			unique case (state_q)
				irbd_pkg::ST_IDLE: if (accept) begin
					for (int k = 0; k < N; k++)
						if (!sensor_levels[k] && hit_q[k] != '1) hit_q[k] <= hit_q[k] + 1'b1;
					samp_q <= win_end ? '0 : samp_nx;
				end
				irbd_pkg::ST_FILTER: begin
					for (int k = 0; k < N; k++) begin
						w_q[k] <= (hit_q[k] < min_q || hit_q[k] > max_q) ? '0 : hit_q[k];
						idx_q[k] <= IW'(k);
						hit_q[k] <= '0;
					end
					i_q <= '0;
				end
				irbd_pkg::ST_FILL: begin
					if (w_q[i_q] == '0 && w_q[ip] != '0 && w_q[inx] != '0)
						w_q[i_q] <= nsum[CW:1];
					i_q <= (i_q == IW'(N-1)) ? '0 : i_q + 1'b1;
					j_q <= 4'd1;
				end
				irbd_pkg::ST_SORT: begin
					// selection sort: slot i against candidate j
					if (swap) begin
						w_q[i_q] <= w_q[j_q]; w_q[j_q] <= w_q[i_q];
						idx_q[i_q] <= idx_q[j_q]; idx_q[j_q] <= idx_q[i_q];
					end
					if (j_q == IW'(N-1)) begin
						i_q <= (i_q == IW'(N-2)) ? '0 : i_q + 1'b1;
						j_q <= i_q + 4'd2;
					end else j_q <= j_q + 1'b1;
					sum_q <= '0;
				end
				irbd_pkg::ST_STR: begin
					sum_q <= sum_q + (CW+IW)'(w_q[i_q]);
					i_q <= i_q + 1'b1;
					j_q <= 4'(CW - 1);
					quo_q <= '0;
				end
				irbd_pkg::ST_DIV: begin
					// restoring division by n, one quotient bit per cycle
					if (sum_q >= dsub) begin
						sum_q <= sum_q - dsub;
						quo_q[j_q] <= 1'b1;
					end
					j_q <= j_q - 1'b1;
					i_q <= '0; si_q <= '0; sj_q <= '0;
				end
				irbd_pkg::ST_VEC: if (i_q < IW'(n_ang)) begin
					si_q <= si_q + prod_s;
					sj_q <= sj_q + prod_c;
					i_q <= i_q + 1'b1;
				end else i_q <= '0;
				irbd_pkg::ST_PRE: begin
					str_q <= (quo_q > 14'd1023) ? 10'd1023 : quo_q[9:0];
					ang_q <= (sj_q == 0) ? -10'sd1 : (sj_q > 0) ? 10'sd0 : 10'sd180;
					i_q <= '0;
				end
				irbd_pkg::ST_CORD: i_q <= i_q + 1'b1;
				irbd_pkg::ST_ROUND:
					ang_q <= 10'(16'sd360 - ((tmod < 0) ? tmod + 16'sd360 : tmod));
				irbd_pkg::ST_DONE: valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign valid = valid_q;
	assign ball_strength = str_q;
	assign ball_angle = ang_q;

	`IRB_ASSERT_IMP(a_valid_idle, clk, arst_n, valid, !busy)
	`IRB_ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == irbd_pkg::ST_DONE, valid)
	`IRB_ASSERT_NEXT(a_win_start, clk, arst_n, accept && win_end, state_q == irbd_pkg::ST_FILTER)
endmodule

### hw/rtl/irbd_cordic.sv
// Vectoring CORDIC step unit: one micro-rotation per cycle while step is high.
// Uses irbd_pkg for the atan table and widths.
module irbd_cordic (
	input  logic                                clk,
	input  logic                                load,
	input  logic                                step,
	input  logic [3:0]                          iter,
	input  logic signed [irbd_pkg::AccW-1:0]    y_in,
	input  logic signed [irbd_pkg::AccW-1:0]    x_in,
	output logic signed [31:0]                  z
);
	localparam int W = irbd_pkg::AccW + 2;
	logic signed [W-1:0] x_q, y_q, dx, dy;
	logic signed [31:0] z_q, at;

	assign dx = y_q >>> iter;
	assign dy = x_q >>> iter;
	assign at = $signed(irbd_pkg::atan_q16(iter));
	assign z  = z_q;

	// pre-rotation into right half plane on load
	always_ff @(posedge clk) begin
		if (load) begin
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_q <= W'(y_in); y_q <= -W'(x_in); z_q <= 32'sd5898240;
				end else begin
					x_q <= -W'(y_in); y_q <= W'(x_in); z_q <= -32'sd5898240;
				end
			end else begin
				x_q <= W'(x_in); y_q <= W'(y_in); z_q <= '0;
			end
		end else if (step) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
			end
		end
	end
endmodule

### tb/tb_top.sv
// Testbench for ir_ring_ball_direction_top: sample windows, ring fill, sort, strength, angle.
// Predicts each window result in SystemVerilog and checks it; depends on the RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSENS = 12;
	localparam logic [4:0] ADDR_SPW = 5'd0, ADDR_MIN = 5'd4, ADDR_MAX = 5'd8,
		ADDR_ANG = 5'd12, ADDR_STR = 5'd16, ADDR_UNUSED = 5'd20;
	localparam int SETTLE = 300;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic [9:0] strength;
		logic signed [9:0] angle;
	} ball_t;

	logic clk, arst_n, start, busy, valid, psel, penable, pwrite, pready;
	logic [11:0] sensor_levels;
	logic [9:0] ball_strength;
	logic signed [9:0] ball_angle;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	ir_ring_ball_direction_top dut (.*);

	// predictor state
	int unsigned hits[NSENS];
	int unsigned win_ctr;
	int unsigned cfg_spw, cfg_min, cfg_max, cfg_ang, cfg_str;
	ball_t expected_balls[$];
	int errors = 0;
	int gap_pct = 0;
	int idle_cycles = 0;

	const longint ATAN_TBL[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void unit_vector(int k, output longint cs, output longint sn);
		int q, r, rest, m;
		longint x, y, z, dx, dy, c, s, t;
		q = (4 * k) / NSENS;
		r = (4 * k) % NSENS;
		if (r == 0) begin
			c = 65536;
			s = 0;
		end else begin
			rest = NSENS - r;
			m = (rest < r) ? rest : r;
			z = (longint'(m) * 90 * 65536 * 2 + NSENS) / (2 * NSENS);
			x = 39797;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ATAN_TBL[i];
				end else begin
					x += dx; y -= dy; z += ATAN_TBL[i];
				end
			end
			c = x;
			s = y;
			if (r == rest) s = c;
			else if (r > rest) begin
				t = c; c = s; s = t;
			end
		end
		case (q & 3)
			0: begin cs = c;  sn = s;  end
			1: begin cs = -s; sn = c;  end
			2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endfunction

	function automatic longint heading_q16(longint y, longint x);
		longint z, t, dx, dy;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 90 * 65536;
			end else begin
				t = x; x = -y; y = t; z = -90 * 65536;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TBL[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TBL[i];
			end
		end
		return z;
	endfunction

	// count one sample; at window end queue the ball estimate
	function automatic void count_sample(logic [11:0] lv);
		int unsigned w[NSENS], rank_cnt[NSENS], rank_idx[NSENS], best, n, p, nx;
		bit taken[NSENS];
		longint unsigned sum;
		longint si, sj, c, s, z, r, t;
		ball_t b;
		for (int k = 0; k < NSENS; k++)
			if (!lv[k] && hits[k] < 1023) hits[k]++;
		win_ctr = (win_ctr + 1) & 10'h3FF;
		if (win_ctr < cfg_spw) return;
		win_ctr = 0;
		for (int k = 0; k < NSENS; k++) begin
			w[k] = (hits[k] < cfg_min || hits[k] > cfg_max) ? 0 : hits[k];
			taken[k] = 0;
		end
		for (int k = 0; k < NSENS; k++) begin
			p = (k == 0) ? NSENS - 1 : k - 1;
			nx = (k == NSENS - 1) ? 0 : k + 1;
			if (w[k] == 0 && w[p] != 0 && w[nx] != 0) w[k] = (w[p] + w[nx]) / 2;
		end
		for (int j = 0; j < NSENS; j++) begin
			best = NSENS;
			for (int k = 0; k < NSENS; k++)
				if (!taken[k] && (best == NSENS || w[k] > w[best])) best = k;
			taken[best] = 1;
			rank_cnt[j] = w[best];
			rank_idx[j] = best;
		end
		n = cfg_str;
		if (n < 1) n = 1;
		if (n > NSENS) n = NSENS;
		sum = 0;
		for (int j = 0; j < n; j++) sum += rank_cnt[j];
		sum /= n;
		if (sum > 1023) sum = 1023;
		n = (cfg_ang > NSENS) ? NSENS : cfg_ang;
		si = 0;
		sj = 0;
		for (int j = 0; j < n; j++) begin
			unit_vector(rank_idx[j], c, s);
			si += longint'(rank_cnt[j]) * s;
			sj += longint'(rank_cnt[j]) * c;
		end
		if (si == 0) t = (sj == 0) ? -1 : (sj > 0 ? 0 : 180);
		else begin
			z = heading_q16(sj, si);
			r = (z >= 0) ? ((z + 32768) >>> 16) : -((-z + 32768) >>> 16);
			t = (270 + r) % 360;
			if (t < 0) t += 360;
			t = 360 - t;
		end
		for (int k = 0; k < NSENS; k++) hits[k] = 0;
		b.strength = sum[9:0];
		b.angle = t[9:0];
		expected_balls.push_back(b);
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && valid) begin
			idle_cycles <= 0;
			if (expected_balls.size() == 0) begin
				$display("%0t: unexpected result strength=%0d angle=%0d",
					$time, ball_strength, ball_angle);
				errors++;
			end else begin
				if (ball_strength !== expected_balls[0].strength) begin
					$display("%0t: ball_strength expected %0d actual %0d", $time,
						expected_balls[0].strength, ball_strength);
					errors++;
				end
				if (ball_angle !== expected_balls[0].angle) begin
					$display("%0t: ball_angle expected %0d actual %0d", $time,
						expected_balls[0].angle, ball_angle);
					errors++;
				end
				void'(expected_balls.pop_front());
			end
		end else if (arst_n && start && !busy) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("[ir_ring_ball_direction_top] ERROR");
			$finish;
		end
	end

	// start stays high after a transaction so samples can follow with no gap
	task automatic send_sample(logic [11:0] lv);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			@(negedge clk);
			start <= 0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1;
		sensor_levels <= lv;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		count_sample(lv);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (expected_balls.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [4:0] addr, logic [31:0] data);
		@(negedge clk);
		start <= 0;
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (addr)
			ADDR_SPW: cfg_spw = data & 10'h3FF;
			ADDR_MIN: cfg_min = data & 10'h3FF;
			ADDR_MAX: cfg_max = data & 10'h3FF;
			ADDR_ANG: cfg_ang = data & 4'hF;
			ADDR_STR: cfg_str = data & 4'hF;
			default: ;
		endcase
	endtask

	task automatic set_all(int spw, int mn, int mx, int ang, int str);
		drain();
		write_reg(ADDR_SPW, spw);
		write_reg(ADDR_MIN, mn);
		write_reg(ADDR_MAX, mx);
		write_reg(ADDR_ANG, ang);
		write_reg(ADDR_STR, str);
	endtask

	function automatic logic [11:0] random_levels();
		int kind, ctr, wid;
		logic [11:0] act;
		kind = $urandom_range(99);
		act = '0;
		if (kind < 60) begin
			ctr = $urandom_range(NSENS - 1);
			wid = $urandom_range(5, 1);
			for (int i = 0; i < wid; i++)
				if ($urandom_range(9) != 0) act[(ctr + i) % NSENS] = 1;
		end else if (kind < 85) act = 12'($urandom);
		else if (kind < 92) act = '1;
		return ~act;
	endfunction

	// directed: single sensors, all/none active, gap fill, degenerate counts
	task automatic test_directed();
		set_all(1, 0, 1023, 4, 3);
		send_sample(12'hFFF);
		send_sample(12'h000);
		for (int k = 0; k < NSENS; k++) send_sample(~(12'h1 << k));
		send_sample(~12'b1010_0000_0101);
		set_all(0, 0, 1023, 0, 0);
		send_sample(12'h000);
		send_sample(12'h5A5);
		set_all(2, 1, 1, 15, 15);
		send_sample(~12'b0000_0000_0011);
		send_sample(~12'b0000_0000_0001);
		set_all(3, 2, 2, 12, 12);
		send_sample(~12'b1000_0000_0011);
		send_sample(~12'b1000_0000_0001);
		send_sample(~12'b1000_0000_0011);
		drain();
		write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
	endtask

	// register lowered below the running count: window ends on the next sample
	task automatic test_window_shortened();
		set_all(20, 0, 1023, 4, 3);
		repeat (6) send_sample(random_levels());
		drain();
		write_reg(ADDR_SPW, 4);
		send_sample(random_levels());
		send_sample(random_levels());
	endtask

	// long window with every sensor active builds large counts and strength
	task automatic test_full_window();
		set_all(511, 0, 1023, 12, 12);
		repeat (511) send_sample(12'h000);
	endtask

	task automatic test_random(int pct);
		gap_pct = pct;
		for (int seg = 0; seg < 10; seg++) begin
			int mn, mx;
			mn = ($urandom_range(3) == 0) ? $urandom_range(6) : 0;
			mx = ($urandom_range(3) == 0) ? $urandom_range(12, 2) : 1023;
			if ($urandom_range(9) == 0) begin
				mn = $urandom_range(1023);
				mx = $urandom_range(1023);
			end
			set_all($urandom_range(9), mn, mx, $urandom_range(15), $urandom_range(15));
			repeat (12) send_sample(random_levels());
		end
	endtask

	initial begin
		arst_n = 0; start = 0; sensor_levels = '1;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		cfg_spw = 255; cfg_min = 0; cfg_max = 1023; cfg_ang = 4; cfg_str = 3;
		win_ctr = 0;
		foreach (hits[k]) hits[k] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_window_shortened();
		test_random(31);
		test_full_window();
		test_random(58);
		test_random(0);
		drain();
		if (errors == 0) $display("[ir_ring_ball_direction_top] OK");
		else $display("[ir_ring_ball_direction_top] ERROR");
		$finish;
	end
endmodule
